// ----- rtl/epd_pkg.sv -----
// Shared constants for the envelope pulse detector: default sizes, register
// indices and reset values, and the fixed scale factors of the tests.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package epd_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int DEF_MAX_SAMPLES = 4096;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_MAX_PULSES  = 32;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_RATIO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_FRACTION    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_THRESHOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_WINDOW = 3'd4;

  localparam logic [CFG_W-1:0] RST_SAMPLE_RATE     = 16'd8000;
  localparam logic [CFG_W-1:0] RST_NEIGHBOR_RATIO  = 16'd512;
  localparam logic [CFG_W-1:0] RST_AMP_FRACTION    = 16'd32768;
  localparam logic [CFG_W-1:0] RST_FREQ_THRESHOLD  = 16'd0;
  localparam logic [CFG_W-1:0] RST_NEIGHBOR_WINDOW = 16'd160;

  // Reported index width
  localparam int OUT_IDX_W = 12;

  // Scale factors: ms per second, duration limits in ms, window step
  // (1000 ms * 16 sixteenths), Q8.8 ratio and Q0.16 fraction bits
  localparam int MS_PER_S    = 1000;
  localparam int DUR_MIN_MS  = 2;
  localparam int DUR_MAX_MS  = 20;
  localparam int WIN_STEP    = 16000;
  localparam int RATIO_FBITS = 8;
  localparam int FRAC_FBITS  = 16;

endpackage

`default_nettype wire

// ----- rtl/envelope_pulse_detector_core.sv -----
// Envelope pulse detector, top level. Stores amplitude and frequency
// envelopes and runs the pulse search after the last sample.
// Depends on epd_pkg, epd_ram and epd_mul.
`timescale 1ns / 1ps
`default_nettype none

// Samples are taken one per cycle (start high while busy is low) and written
// to two sample RAMs; there is no clearing pass after reset. A sample with
// in_last_sample set starts the detection pass, during which busy stays high.
// The pass forms two setup products, scans every stored sample against the
// threshold, and for every closed run of legal length sweeps the run and each
// neighbour window and forms up to eight products. The threshold, window-limit
// and check products go through one shared shift-add multiplier.
// Results then leave one at a time, each shown for exactly one
// cycle with out_valid; the receiver cannot stall, so take them as they come.
// A pass that finds nothing gives one empty result with out_last_result set.
module envelope_pulse_detector_core
  import epd_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int MAX_PULSES  = DEF_MAX_PULSES
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // sample request
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [SAMPLE_BITS-1:0] in_amp_sample,
  input  wire logic [SAMPLE_BITS-1:0] in_freq_sample,
  input  wire logic                   in_last_sample,
  // results
  output logic                        out_valid,
  output logic [OUT_IDX_W-1:0]        out_pulse_start,
  output logic [OUT_IDX_W-1:0]        out_pulse_end,
  output logic                        out_pulse_found,
  output logic                        out_overflow,
  output logic                        out_last_result,
  // configuration
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data
);

  localparam int SB     = SAMPLE_BITS;
  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SB + CNT_W;
  localparam int A_W    = (SUM_W > CFG_W) ? SUM_W : CFG_W;
  localparam int B_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int PR_W   = A_W + B_W;
  localparam int TH_W   = SB + FRAC_FBITS;
  localparam int LIM_W  = 2 * CFG_W;
  localparam int D_W    = CNT_W + 14;
  localparam int FC_W   = (SB > CFG_W) ? SB : CFG_W;
  localparam int DUR_W  = (IDX_W + 10 > CFG_W + 5) ? IDX_W + 10 : CFG_W + 5;
  localparam int PC_W   = $clog2(MAX_PULSES + 1);
  localparam int PA_W   = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;

  // sequencer states
  localparam logic [4:0] S_LOAD   = 5'd0;
  localparam logic [4:0] S_THR_GO = 5'd1;
  localparam logic [4:0] S_THR_W  = 5'd2;
  localparam logic [4:0] S_LIM_GO = 5'd3;
  localparam logic [4:0] S_LIM_W  = 5'd4;
  localparam logic [4:0] S_SC_RD  = 5'd5;
  localparam logic [4:0] S_SC_EV  = 5'd6;
  localparam logic [4:0] S_DUR    = 5'd7;
  localparam logic [4:0] S_PR_RD  = 5'd8;
  localparam logic [4:0] S_PR_EV  = 5'd9;
  localparam logic [4:0] S_LW_RD  = 5'd10;
  localparam logic [4:0] S_LW_EV  = 5'd11;
  localparam logic [4:0] S_RW_RD  = 5'd12;
  localparam logic [4:0] S_RW_EV  = 5'd13;
  localparam logic [4:0] S_CK_GO  = 5'd14;
  localparam logic [4:0] S_CK_W   = 5'd15;
  localparam logic [4:0] S_EM_SET = 5'd16;
  localparam logic [4:0] S_EM_RD  = 5'd17;
  localparam logic [4:0] S_EM_OUT = 5'd18;

  // qualification checks, in order
  localparam logic [2:0] CK_AMP_L  = 3'd0;
  localparam logic [2:0] CK_AMP_R  = 3'd1;
  localparam logic [2:0] CK_FRQ_L  = 3'd2;
  localparam logic [2:0] CK_FRQ_R  = 3'd3;
  localparam logic [2:0] CK_MEAN_L = 3'd4;
  localparam logic [2:0] CK_XL     = 3'd5;
  localparam logic [2:0] CK_MEAN_R = 3'd6;
  localparam logic [2:0] CK_XR     = 3'd7;

  // configuration registers
  logic [CFG_W-1:0] rate_r, ratio_r, frac_r, fthr_r, win_r;

  // control state
  logic [4:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SB-1:0]    peak_r, peak_nxt;
  logic             inrun_r, inrun_nxt;
  logic [PC_W-1:0]  em_r, em_nxt;
  logic             ovf_r, ovf_nxt;
  logic             ov_valid_r, ov_valid_nxt;

  // pass working registers
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [PC_W-1:0]  k_r, k_nxt;
  logic [TH_W-1:0]  thr_r, thr_nxt;
  logic [LIM_W-1:0] lim_r, lim_nxt;
  logic [IDX_W-1:0] rs_r, rs_nxt, re_r, re_nxt;
  logic [D_W-1:0]   dist_r, dist_nxt;
  logic [SB-1:0]    pmax_r, pmax_nxt, fmax_r, fmax_nxt;
  logic [SB-1:0]    lmin_r, lmin_nxt, lfmin_r, lfmin_nxt;
  logic [SB-1:0]    rmin_r, rmin_nxt, rfmin_r, rfmin_nxt;
  logic [SUM_W-1:0] psum_r, psum_nxt, lsum_r, lsum_nxt, rsum_r, rsum_nxt;
  logic [CNT_W-1:0] pcnt_r, pcnt_nxt, lcnt_r, lcnt_nxt, rcnt_r, rcnt_nxt;
  logic [2:0]       chk_r, chk_nxt;
  logic             flok_r, flok_nxt;
  logic [PR_W-1:0]  px_r, px_nxt;

  // result payload
  logic [OUT_IDX_W-1:0] os_r, os_nxt, oe_r, oe_nxt;
  logic                 of_r, of_nxt, oo_r, oo_nxt, ol_r, ol_nxt;

  // memories and multiplier
  logic                  s_we;
  logic [IDX_W-1:0]      s_waddr, s_raddr;
  logic [SB-1:0]         s_amp_wd, s_frq_wd, amp_rd, frq_rd;
  logic                  p_we;
  logic [PA_W-1:0]       p_waddr, p_raddr;
  logic [2*IDX_W-1:0]    p_wd, p_rd;
  logic                  mul_go, mul_done;
  logic [A_W-1:0]        mul_a;
  logic [B_W-1:0]        mul_b;
  logic [PR_W-1:0]       mul_p;

  // helpers
  logic [SB-1:0]         samp_a, samp_f;
  logic                  cand;
  logic [CNT_W-1:0]      i_m1;
  logic [DUR_W-1:0]      dur_v, dur_lo, dur_hi;
  logic [D_W-1:0]        dist_step;
  logic                  win_end;
  logic [SB-1:0]         m_sel, pk_sel;
  logic                  ratio_ok;
  logic [IDX_W+OUT_IDX_W-1:0] st_ext, en_ext;

  epd_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_amp_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_amp_wd),
    .raddr(s_raddr), .rdata(amp_rd)
  );

  epd_ram #(.WIDTH(SB), .DEPTH(MAX_SAMPLES)) u_frq_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_frq_wd),
    .raddr(s_raddr), .rdata(frq_rd)
  );

  epd_ram #(.WIDTH(2 * IDX_W), .DEPTH(MAX_PULSES)) u_pulse_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wd),
    .raddr(p_raddr), .rdata(p_rd)
  );

  epd_mul #(.A_W(A_W), .B_W(B_W)) u_mul (
    .clk(clk), .rst_n(rst_n), .go(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  // sample zero is forced to zero
  assign samp_a = (cnt_r == '0) ? '0 : in_amp_sample;
  assign samp_f = (cnt_r == '0) ? '0 : in_freq_sample;

  // run candidate test on the sample just read
  assign cand = ({amp_rd, {FRAC_FBITS{1'b0}}} > thr_r) &&
                (FC_W'(frq_rd) > FC_W'(fthr_r));
  assign i_m1 = i_r - CNT_W'(1);

  // run length in ms against the legal range
  assign dur_v  = DUR_W'(re_r - rs_r) * DUR_W'(MS_PER_S);
  assign dur_lo = DUR_W'(rate_r) * DUR_W'(DUR_MIN_MS);
  assign dur_hi = DUR_W'(rate_r) * DUR_W'(DUR_MAX_MS);

  // neighbour window: next sample lies one step further out
  assign dist_step = dist_r + D_W'(WIN_STEP);
  assign win_end   = LIM_W'(dist_step) > lim_r;

  // peak against ratio times neighbour minimum
  always_comb begin
    case (chk_r)
      CK_AMP_L: begin m_sel = lmin_r;  pk_sel = pmax_r; end
      CK_AMP_R: begin m_sel = rmin_r;  pk_sel = pmax_r; end
      CK_FRQ_L: begin m_sel = lfmin_r; pk_sel = fmax_r; end
      CK_FRQ_R: begin m_sel = rfmin_r; pk_sel = fmax_r; end
      default:  begin m_sel = lmin_r;  pk_sel = pmax_r; end
    endcase
  end
  assign ratio_ok = (m_sel == '0) ||
                    (PR_W'({pk_sel, {RATIO_FBITS{1'b0}}}) > mul_p);

  // stored pulse indices, cut to the reported width
  assign st_ext = (IDX_W + OUT_IDX_W)'(p_rd[2*IDX_W-1:IDX_W]);
  assign en_ext = (IDX_W + OUT_IDX_W)'(p_rd[IDX_W-1:0]);

  // memory addressing
  assign s_waddr  = cnt_r[IDX_W-1:0];
  assign s_amp_wd = samp_a;
  assign s_frq_wd = samp_f;
  assign s_raddr  = (state_r == S_SC_RD) ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];
  assign p_waddr  = em_r[PA_W-1:0];
  assign p_wd     = {rs_r, re_r};
  assign p_raddr  = k_r[PA_W-1:0];

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    peak_nxt     = peak_r;
    inrun_nxt    = inrun_r;
    em_nxt       = em_r;
    ovf_nxt      = ovf_r;
    ov_valid_nxt = 1'b0;
    n_nxt        = n_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    thr_nxt      = thr_r;
    lim_nxt      = lim_r;
    rs_nxt       = rs_r;
    re_nxt       = re_r;
    dist_nxt     = dist_r;
    pmax_nxt     = pmax_r;
    fmax_nxt     = fmax_r;
    lmin_nxt     = lmin_r;
    lfmin_nxt    = lfmin_r;
    rmin_nxt     = rmin_r;
    rfmin_nxt    = rfmin_r;
    psum_nxt     = psum_r;
    lsum_nxt     = lsum_r;
    rsum_nxt     = rsum_r;
    pcnt_nxt     = pcnt_r;
    lcnt_nxt     = lcnt_r;
    rcnt_nxt     = rcnt_r;
    chk_nxt      = chk_r;
    flok_nxt     = flok_r;
    px_nxt       = px_r;
    os_nxt       = os_r;
    oe_nxt       = oe_r;
    of_nxt       = of_r;
    oo_nxt       = oo_r;
    ol_nxt       = ol_r;
    s_we         = 1'b0;
    p_we         = 1'b0;
    mul_go       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;

    case (state_r)
      // take samples until the last one
      S_LOAD: begin
        if (start) begin
          if (cnt_r < CNT_W'(MAX_SAMPLES)) begin
            s_we    = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
            if (samp_a > peak_r) begin
              peak_nxt = samp_a;
            end
          end
          if (in_last_sample) begin
            n_nxt     = (cnt_r < CNT_W'(MAX_SAMPLES)) ? cnt_r + CNT_W'(1) : cnt_r;
            state_nxt = S_THR_GO;
          end
        end
      end

      // amplitude threshold = fraction * peak
      S_THR_GO: begin
        mul_go    = 1'b1;
        mul_a     = A_W'(peak_r);
        mul_b     = B_W'(frac_r);
        state_nxt = S_THR_W;
      end
      S_THR_W: begin
        if (mul_done) begin
          thr_nxt   = mul_p[TH_W-1:0];
          state_nxt = S_LIM_GO;
        end
      end

      // window limit = window * rate
      S_LIM_GO: begin
        mul_go    = 1'b1;
        mul_a     = A_W'(win_r);
        mul_b     = B_W'(rate_r);
        state_nxt = S_LIM_W;
      end
      S_LIM_W: begin
        if (mul_done) begin
          lim_nxt   = mul_p[LIM_W-1:0];
          i_nxt     = '0;
          inrun_nxt = 1'b0;
          em_nxt    = '0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = '0;
          peak_nxt  = '0;
          state_nxt = S_SC_RD;
        end
      end

      // threshold scan over the stored samples
      S_SC_RD: begin
        state_nxt = (i_r == n_r) ? S_EM_SET : S_SC_EV;
      end
      S_SC_EV: begin
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_SC_RD;
        if (cand) begin
          if (!inrun_r) begin
            inrun_nxt = 1'b1;
            rs_nxt    = i_r[IDX_W-1:0];
          end
        end else if (inrun_r) begin
          inrun_nxt = 1'b0;
          re_nxt    = i_m1[IDX_W-1:0];
          state_nxt = S_DUR;
        end
      end

      // duration test, then sweep the run itself
      S_DUR: begin
        if (dur_v < dur_lo || dur_v > dur_hi) begin
          state_nxt = S_SC_RD;
        end else begin
          j_nxt     = CNT_W'(rs_r);
          pmax_nxt  = '0;
          fmax_nxt  = '0;
          psum_nxt  = '0;
          pcnt_nxt  = '0;
          state_nxt = S_PR_RD;
        end
      end
      S_PR_RD: state_nxt = S_PR_EV;
      S_PR_EV: begin
        if (amp_rd > pmax_r) pmax_nxt = amp_rd;
        if (frq_rd > fmax_r) fmax_nxt = frq_rd;
        psum_nxt = psum_r + SUM_W'(amp_rd);
        pcnt_nxt = pcnt_r + CNT_W'(1);
        if (j_r[IDX_W-1:0] == re_r) begin
          j_nxt     = CNT_W'(rs_r);
          dist_nxt  = '0;
          lmin_nxt  = '1;
          lfmin_nxt = '1;
          lsum_nxt  = '0;
          lcnt_nxt  = '0;
          state_nxt = S_LW_RD;
        end else begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = S_PR_RD;
        end
      end

      // left window, walking down from the run start
      S_LW_RD: state_nxt = S_LW_EV;
      S_LW_EV: begin
        if (amp_rd < lmin_r)  lmin_nxt  = amp_rd;
        if (frq_rd < lfmin_r) lfmin_nxt = frq_rd;
        lsum_nxt = lsum_r + SUM_W'(amp_rd);
        lcnt_nxt = lcnt_r + CNT_W'(1);
        if (j_r == '0 || win_end) begin
          j_nxt     = CNT_W'(re_r);
          dist_nxt  = '0;
          rmin_nxt  = '1;
          rfmin_nxt = '1;
          rsum_nxt  = '0;
          rcnt_nxt  = '0;
          state_nxt = S_RW_RD;
        end else begin
          j_nxt     = j_r - CNT_W'(1);
          dist_nxt  = dist_step;
          state_nxt = S_LW_RD;
        end
      end

      // right window, walking up from the run end
      S_RW_RD: state_nxt = S_RW_EV;
      S_RW_EV: begin
        if (amp_rd < rmin_r)  rmin_nxt  = amp_rd;
        if (frq_rd < rfmin_r) rfmin_nxt = frq_rd;
        rsum_nxt = rsum_r + SUM_W'(amp_rd);
        rcnt_nxt = rcnt_r + CNT_W'(1);
        if (j_r + CNT_W'(1) == n_r || win_end) begin
          chk_nxt   = CK_AMP_L;
          state_nxt = S_CK_GO;
        end else begin
          j_nxt     = j_r + CNT_W'(1);
          dist_nxt  = dist_step;
          state_nxt = S_RW_RD;
        end
      end

      // one product per check
      S_CK_GO: begin
        mul_go = 1'b1;
        case (chk_r)
          CK_AMP_L:  begin mul_a = A_W'(lmin_r);  mul_b = B_W'(ratio_r); end
          CK_AMP_R:  begin mul_a = A_W'(rmin_r);  mul_b = B_W'(ratio_r); end
          CK_FRQ_L:  begin mul_a = A_W'(lfmin_r); mul_b = B_W'(ratio_r); end
          CK_FRQ_R:  begin mul_a = A_W'(rfmin_r); mul_b = B_W'(ratio_r); end
          CK_MEAN_L: begin mul_a = A_W'(psum_r);  mul_b = B_W'(lcnt_r);  end
          CK_XL:     begin mul_a = A_W'(lsum_r);  mul_b = B_W'(pcnt_r);  end
          CK_MEAN_R: begin mul_a = A_W'(psum_r);  mul_b = B_W'(rcnt_r);  end
          CK_XR:     begin mul_a = A_W'(rsum_r);  mul_b = B_W'(pcnt_r);  end
          default:   begin mul_a = '0;            mul_b = '0;            end
        endcase
        state_nxt = S_CK_W;
      end
      S_CK_W: begin
        if (mul_done) begin
          chk_nxt   = chk_r + 3'd1;
          state_nxt = S_CK_GO;
          case (chk_r)
            CK_AMP_L, CK_AMP_R: begin
              if (!ratio_ok) state_nxt = S_SC_RD;
            end
            CK_FRQ_L: flok_nxt = ratio_ok;
            CK_FRQ_R: begin
              if (!(flok_r || ratio_ok)) state_nxt = S_SC_RD;
            end
            CK_MEAN_L, CK_MEAN_R: px_nxt = mul_p;
            CK_XL: begin
              if (!(px_r > mul_p)) state_nxt = S_SC_RD;
            end
            CK_XR: begin
              state_nxt = S_SC_RD;
              if (px_r > mul_p) begin
                if (em_r < PC_W'(MAX_PULSES)) begin
                  p_we   = 1'b1;
                  em_nxt = em_r + PC_W'(1);
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
            end
            default: state_nxt = S_SC_RD;
          endcase
        end
      end

      // report
      S_EM_SET: begin
        if (em_r == '0) begin
          ov_valid_nxt = 1'b1;
          os_nxt       = '0;
          oe_nxt       = '0;
          of_nxt       = 1'b0;
          oo_nxt       = 1'b0;
          ol_nxt       = 1'b1;
          state_nxt    = S_LOAD;
        end else begin
          k_nxt     = '0;
          state_nxt = S_EM_RD;
        end
      end
      S_EM_RD: state_nxt = S_EM_OUT;
      S_EM_OUT: begin
        ov_valid_nxt = 1'b1;
        os_nxt       = st_ext[OUT_IDX_W-1:0];
        oe_nxt       = en_ext[OUT_IDX_W-1:0];
        of_nxt       = 1'b1;
        oo_nxt       = ovf_r;
        ol_nxt       = (k_r + PC_W'(1) == em_r);
        if (k_r + PC_W'(1) == em_r) begin
          state_nxt = S_LOAD;
        end else begin
          k_nxt     = k_r + PC_W'(1);
          state_nxt = S_EM_RD;
        end
      end

      default: state_nxt = S_LOAD;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      cnt_r      <= '0;
      peak_r     <= '0;
      inrun_r    <= 1'b0;
      em_r       <= '0;
      ovf_r      <= 1'b0;
      ov_valid_r <= 1'b0;
      rate_r     <= RST_SAMPLE_RATE;
      ratio_r    <= RST_NEIGHBOR_RATIO;
      frac_r     <= RST_AMP_FRACTION;
      fthr_r     <= RST_FREQ_THRESHOLD;
      win_r      <= RST_NEIGHBOR_WINDOW;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      peak_r     <= peak_nxt;
      inrun_r    <= inrun_nxt;
      em_r       <= em_nxt;
      ovf_r      <= ovf_nxt;
      ov_valid_r <= ov_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLE_RATE:     rate_r  <= cfg_data;
          REG_NEIGHBOR_RATIO:  ratio_r <= cfg_data;
          REG_AMP_FRACTION:    frac_r  <= cfg_data;
          REG_FREQ_THRESHOLD:  fthr_r  <= cfg_data;
          REG_NEIGHBOR_WINDOW: win_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    thr_r   <= thr_nxt;
    lim_r   <= lim_nxt;
    rs_r    <= rs_nxt;
    re_r    <= re_nxt;
    dist_r  <= dist_nxt;
    pmax_r  <= pmax_nxt;
    fmax_r  <= fmax_nxt;
    lmin_r  <= lmin_nxt;
    lfmin_r <= lfmin_nxt;
    rmin_r  <= rmin_nxt;
    rfmin_r <= rfmin_nxt;
    psum_r  <= psum_nxt;
    lsum_r  <= lsum_nxt;
    rsum_r  <= rsum_nxt;
    pcnt_r  <= pcnt_nxt;
    lcnt_r  <= lcnt_nxt;
    rcnt_r  <= rcnt_nxt;
    chk_r   <= chk_nxt;
    flok_r  <= flok_nxt;
    px_r    <= px_nxt;
    os_r    <= os_nxt;
    oe_r    <= oe_nxt;
    of_r    <= of_nxt;
    oo_r    <= oo_nxt;
    ol_r    <= ol_nxt;
  end

  assign busy            = (state_r != S_LOAD);
  assign cfg_ready       = 1'b1;
  assign out_valid       = ov_valid_r;
  assign out_pulse_start = os_r;
  assign out_pulse_end   = oe_r;
  assign out_pulse_found = of_r;
  assign out_overflow    = oo_r;
  assign out_last_result = ol_r;

  // a result only follows one of the report states
  assert property (@(posedge clk) disable iff (!rst_n)
    ov_valid_r |-> ($past(state_r) == S_EM_SET || $past(state_r) == S_EM_OUT))
    else $error("result strobe outside the report phase");
  // the final result of a pass leaves the block ready for samples
  assert property (@(posedge clk) disable iff (!rst_n)
    ov_valid_r && ol_r |-> state_r == S_LOAD)
    else $error("last result while the pass is still running");
  // the pulse buffer never holds more than its depth
  assert property (@(posedge clk) disable iff (!rst_n) em_r <= PC_W'(MAX_PULSES))
    else $error("pulse count beyond buffer depth");
  // the sample count never passes the store depth
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store depth");
  // an empty report carries no overflow flag and is the last result
  assert property (@(posedge clk) disable iff (!rst_n)
    ov_valid_r && !of_r |-> !oo_r && ol_r)
    else $error("empty report with wrong flags");

endmodule

`default_nettype wire

// ----- rtl/epd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module epd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/epd_mul.sv -----
// Shift-and-add multiplier, one bit of the b operand per cycle; the shared
// unit for the detector's threshold, window-limit and check products.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module epd_mul #(
  parameter int A_W = 16,
  parameter int B_W = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic                    done,
  output logic [A_W+B_W-1:0]      p
);

  localparam int PR_W  = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PR_W-1:0]  acc_r, acc_nxt;
  logic [PR_W-1:0]  mc_r, mc_nxt;
  logic [B_W-1:0]   mp_r, mp_nxt;

  // one partial product per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(B_W);
      acc_nxt  = '0;
      mc_nxt   = PR_W'(a);
      mp_nxt   = b;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_nxt = acc_r + mc_r;
      end
      mc_nxt  = {mc_r[PR_W-2:0], 1'b0};
      mp_nxt  = {1'b0, mp_r[B_W-1:1]};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;

  // a new product is only started on an idle unit
  assert property (@(posedge clk) disable iff (!rst_n) go |-> !busy_r)
    else $error("epd_mul: start while busy");
  // done follows the last step of a product
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r))
    else $error("epd_mul: done without a product in flight");
  // the bit counter does not run out while a product is in flight
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != '0)
    else $error("epd_mul: bit counter ran out while busy");

endmodule

`default_nettype wire
